[rtl/core/utf8d_pkg.sv]
// Shared types, constants and helpers of the UTF-8 to UCS-2 decoder.
package utf8d_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
      logic        truncated;
   } rsp_item_type;

   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } dec_result_type;

   localparam logic [7:0] LEAD2_MASK = 8'h1f;
   localparam logic [7:0] LEAD3_MASK = 8'h0f;
   localparam logic [7:0] CONT_MASK  = 8'h3f;

   localparam logic [3:0] NIB_LAST_SINGLE = 4'hb;
   localparam logic [3:0] NIB_LAST_LEAD2  = 4'hd;
   localparam logic [3:0] NIB_LEAD3       = 4'he;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_ONE   = 2'd1;
   localparam logic [1:0] PEND_TWO   = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   // fill missing continuation bytes with zero
   function automatic logic [15:0] pad_missing(input logic [15:0] value,
                                               input logic [1:0]  missing);
      logic [15:0] result;
      unique case (missing)
         PEND_NONE:  result = value;
         PEND_ONE:   result = {value[9:0], 6'd0};
         PEND_TWO:   result = {value[3:0], 12'd0};
         PEND_THREE: result = 16'd0;
         default:    result = value;
      endcase
      return result;
   endfunction

endpackage

[rtl/core/utf8d_in_stage.sv]
// Input register stage of the UTF-8 to UCS-2 decoder.
module utf8d_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  utf8d_pkg::req_item_type req_item,
   input  logic                   advance,
   output logic                   stage_valid,
   output utf8d_pkg::req_item_type stage_item
);
   import utf8d_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

[rtl/core/utf8d_decode.sv]
// Sequence state and single-pass decode of one byte.
module utf8d_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  utf8d_pkg::req_item_type  stage_item,
   output utf8d_pkg::dec_result_type dec_result
);
   import utf8d_pkg::*;

   logic [1:0]  pending_ff;
   logic [1:0]  pending_in;
   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic [7:0]  b;
   logic [3:0]  nib;
   logic        eot;
   logic [15:0] acc_next;
   logic [1:0]  pend_next;

   assign b   = stage_item.byte_in;
   assign nib = b[7:4];
   assign eot = stage_item.end_of_text;

   always_comb begin
      acc_next   = 16'd0;
      pend_next  = PEND_NONE;
      pending_in = pending_ff;
      acc_in     = acc_ff;
      dec_result = '0;
      if (pending_ff == PEND_NONE) begin
         priority if (nib <= NIB_LAST_SINGLE) begin
            acc_next  = 16'd0;
            pend_next = PEND_NONE;
         end else if (nib <= NIB_LAST_LEAD2) begin
            acc_next  = {8'd0, b & LEAD2_MASK};
            pend_next = PEND_ONE;
         end else if (nib == NIB_LEAD3) begin
            acc_next  = {8'd0, b & LEAD3_MASK};
            pend_next = PEND_TWO;
         end else begin
            acc_next  = 16'd0;
            pend_next = PEND_THREE;
         end
      end else begin
         acc_next  = {acc_ff[9:0], b[5:0] & CONT_MASK[5:0]};
         pend_next = pending_ff - PEND_ONE;
      end

      if (pending_ff == PEND_NONE && nib <= NIB_LAST_SINGLE) begin
         dec_result.emit           = 1'b1;
         dec_result.item.code_unit = {8'd0, b};
         dec_result.item.last_unit = eot;
         dec_result.item.truncated = 1'b0;
         pending_in = PEND_NONE;
         acc_in     = 16'd0;
      end else if (pending_ff != PEND_NONE && pend_next == PEND_NONE) begin
         dec_result.emit           = 1'b1;
         dec_result.item.code_unit = acc_next;
         dec_result.item.last_unit = eot;
         dec_result.item.truncated = 1'b0;
         pending_in = PEND_NONE;
         acc_in     = 16'd0;
      end else if (eot) begin
         dec_result.emit           = 1'b1;
         dec_result.item.code_unit = pad_missing(acc_next, pend_next);
         dec_result.item.last_unit = 1'b1;
         dec_result.item.truncated = 1'b1;
         pending_in = PEND_NONE;
         acc_in     = 16'd0;
      end else begin
         pending_in = pend_next;
         acc_in     = acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         acc_ff     <= 16'd0;
      end else if (advance) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

[rtl/core/utf8d_out_stage.sv]
// Result register of the UTF-8 to UCS-2 decoder.
module utf8d_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  utf8d_pkg::dec_result_type dec_result,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output utf8d_pkg::rsp_item_type   rsp_item
);
   import utf8d_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = advance ? dec_result.emit : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec_result.emit) begin
         item_ff <= dec_result.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[rtl/core/utf8_to_ucs2_decoder.sv]
// Top level of the UTF-8 to UCS-2 decoder.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | byte_in, end_of_text
//   rsp     | out       | rsp_valid/rsp_stall  | code_unit, last_unit, truncated
//
// A byte is taken every cycle unless rsp stalls; each result is registered.
// Throughput is set by the input register feeding the result register directly.
// Reset clears valid flags and the pending count; the first byte after is a lead.
// A stalled result holds the input register, which then stalls req.
module utf8_to_ucs2_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  utf8d_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output utf8d_pkg::rsp_item_type rsp_item
);
   import utf8d_pkg::*;

   logic           stage_valid;
   req_item_type   stage_item;
   logic           out_free;
   logic           advance;
   dec_result_type dec_result;

   assign advance = stage_valid && out_free;

   utf8d_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   utf8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .stage_item (stage_item),
      .dec_result (dec_result)
   );

   utf8d_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .dec_result (dec_result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/core/utf8d_checker.sv]
// Port-level checks of the UTF-8 to UCS-2 decoder and their binding.
module utf8d_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input utf8d_pkg::req_item_type req_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input utf8d_pkg::rsp_item_type rsp_item
);
   import utf8d_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("stalled request item changed or dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.truncated |-> rsp_item.last_unit)
      else $error("truncated item not marked last");

   a_trunc_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.truncated |-> rsp_item.code_unit[5:0] == 6'd0)
      else $error("truncated item lacks zero padding");

endmodule

bind utf8_to_ucs2_decoder utf8d_checker u_utf8d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
